### rtl/sws_pkg.sv
// Shared constants, codes, types and helpers of the sliding-window sender.
package sws_pkg;

  localparam int WINDOW = 64;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int EFF_W  = 11;
  localparam int SEQ_W  = 32;
  localparam int RTT_W  = 36;

  localparam logic [SEQ_W-1:0] RTO_RESET = 32'd1000;
  localparam logic [EFF_W-1:0] WIN_RESET = 11'd64;
  localparam logic [9:0]       MDEV_RESET = 10'd10;
  localparam logic [2:0]       DUP_MAX   = 3'd7;
  localparam logic [2:0]       DUP_FAST  = 3'd3;

  // transaction modes
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_ACK  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // result actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_TIMEOUT = 3'd2;
  localparam logic [2:0] ACT_FAST    = 3'd3;
  localparam logic [2:0] ACT_REFUSED = 3'd4;
  localparam logic [2:0] ACT_DONE    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_INIT_WIN  = 2'd0;
  localparam logic [1:0] CFG_INIT_RTO  = 2'd1;
  localparam logic [1:0] CFG_MIN_DEV   = 2'd2;
  localparam logic [1:0] CFG_TOTAL_PKT = 2'd3;

  typedef struct packed {
    logic             start;
    logic             take;
    logic             first;
    logic [SEQ_W-1:0] elapsed;
    logic             rto_load;
    logic [15:0]      rto_init;
    logic [9:0]       min_dev;
  } rtt_cmd_t;

  typedef struct packed {
    logic             done;
    logic [RTT_W-1:0] est;
    logic [RTT_W-1:0] dev;
    logic [SEQ_W-1:0] rto;
  } rtt_stat_t;

  function automatic logic [SLOT_W-1:0] slot(input logic [SEQ_W-1:0] seq);
    return seq[SLOT_W-1:0];
  endfunction

  // a is at or after b in wrapping time
  function automatic logic reached(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return ~d[SEQ_W-1];
  endfunction

  function automatic logic [EFF_W-1:0] cap_win(input logic [SEQ_W-1:0] w);
    return (w < SEQ_W'(WINDOW)) ? w[EFF_W-1:0] : EFF_W'(WINDOW);
  endfunction

  function automatic logic [SEQ_W-1:0] sat_inc(input logic [SEQ_W-1:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

endpackage

### rtl/sws_ring.sv
// Transmit-time ring: one write port, two registered read ports.
module sws_ring (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [sws_pkg::SLOT_W-1:0] wr_addr,
  input  logic [sws_pkg::SEQ_W-1:0]  wr_data,
  input  logic [sws_pkg::SLOT_W-1:0] rd_addr_a,
  input  logic [sws_pkg::SLOT_W-1:0] rd_addr_b,
  output logic [sws_pkg::SEQ_W-1:0]  rd_data_a,
  output logic [sws_pkg::SEQ_W-1:0]  rd_data_b
);
  import sws_pkg::*;

  logic [SEQ_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### rtl/sws_rtt.sv
// RTT estimator: smoothed RTT, deviation and RTO, one step per cycle.
module sws_rtt (
  input  logic               clk,
  input  logic               rst_n,
  input  sws_pkg::rtt_cmd_t  cmd,
  output sws_pkg::rtt_stat_t stat
);
  import sws_pkg::*;

  typedef enum logic [2:0] {
    R_IDLE,
    R_EST,
    R_DIFF,
    R_DEV,
    R_RTO
  } rstate_t;

  rstate_t          state_r, state_nxt;
  logic [RTT_W-1:0] last_r, last_nxt;
  logic [RTT_W-1:0] est_r, est_nxt;
  logic [RTT_W-1:0] dev_r, dev_nxt;
  logic [RTT_W-1:0] diff_r, diff_nxt;
  logic [SEQ_W-1:0] rto_r, rto_nxt;
  logic             first_r, first_nxt;
  logic             done_r, done_nxt;

  logic [38:0]      est_sum;
  logic [37:0]      dev_sum;
  logic [RTT_W-1:0] floor_dev;
  logic [RTT_W-1:0] dev_max;
  logic [38:0]      rto_sum;

  always_comb begin
    // 7*est + sample stays below 2^39
    est_sum   = ({3'b0, est_r} << 3) - {3'b0, est_r} + {3'b0, last_r};
    dev_sum   = ({2'b0, dev_r} << 1) + {2'b0, dev_r} + {2'b0, diff_r};
    floor_dev = {22'b0, cmd.min_dev, 4'b0};
    dev_max   = (dev_r > floor_dev) ? dev_r : floor_dev;
    rto_sum   = {3'b0, est_r} + {1'b0, dev_max, 2'b0};

    state_nxt = state_r;
    last_nxt  = last_r;
    est_nxt   = est_r;
    dev_nxt   = dev_r;
    diff_nxt  = diff_r;
    rto_nxt   = rto_r;
    first_nxt = first_r;
    done_nxt  = 1'b0;

    case (state_r)
      R_IDLE: begin
        if (cmd.start) begin
          if (cmd.take) begin
            last_nxt = {cmd.elapsed, 4'b0};
          end
          first_nxt = cmd.first;
          state_nxt = R_EST;
        end
      end
      R_EST: begin
        est_nxt   = first_r ? last_r : est_sum[38:3];
        state_nxt = R_DIFF;
      end
      R_DIFF: begin
        diff_nxt  = (last_r > est_r) ? last_r - est_r : est_r - last_r;
        state_nxt = R_DEV;
      end
      R_DEV: begin
        if (!first_r) begin
          dev_nxt = dev_sum[37:2];
        end
        state_nxt = R_RTO;
      end
      R_RTO: begin
        rto_nxt   = (|rto_sum[38:36]) ? '1 : rto_sum[35:4];
        done_nxt  = 1'b1;
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase

    if (cmd.rto_load) begin
      rto_nxt = {16'b0, cmd.rto_init};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      last_r  <= '0;
      est_r   <= '0;
      dev_r   <= '0;
      rto_r   <= RTO_RESET;
      first_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      est_r   <= est_nxt;
      dev_r   <= dev_nxt;
      rto_r   <= rto_nxt;
      first_r <= first_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
  end

  assign stat.done = done_r;
  assign stat.est  = est_r;
  assign stat.dev  = dev_r;
  assign stat.rto  = rto_r;

endmodule

### rtl/sliding_window_sender_top.sv
// Sliding-window sender: top level with window control, timer and result register.
// Send requests, ticks, duplicate/stale ACKs and mode codes without meaning
// can be accepted in back-to-back cycles while the result register drains.
// An advancing ACK blocks acceptance of the next transaction until it is done:
// two reads of the transmit-time ring (two registered ports each), forming
// the sample, four steps of the RTT estimator (estimate, difference,
// deviation, RTO), then the timer restart; no other transaction is accepted
// meanwhile. After the transfer completes every transaction reports done and
// changes nothing.
module sliding_window_sender_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_mode,
  input  logic [sws_pkg::SEQ_W-1:0] in_ack_seq,
  input  logic [sws_pkg::SEQ_W-1:0] in_recv_window,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_action,
  output logic [sws_pkg::SEQ_W-1:0] out_packet_seq,
  output logic [sws_pkg::SEQ_W-1:0] out_window_base,
  output logic [sws_pkg::SEQ_W-1:0] out_next_sequence,
  output logic [sws_pkg::SEQ_W-1:0] out_rto_now,
  output logic [sws_pkg::RTT_W-1:0] out_smoothed_rtt,
  output logic [sws_pkg::RTT_W-1:0] out_rtt_deviation,
  output logic [sws_pkg::EFF_W-1:0] out_effective_window,
  output logic [sws_pkg::SEQ_W-1:0] out_timeout_count,
  output logic [sws_pkg::SEQ_W-1:0] out_fast_retx_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import sws_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WAIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [SEQ_W-1:0] now_r, now_nxt;
  logic [SEQ_W-1:0] timer_r, timer_nxt;
  logic [2:0]       dup_r, dup_nxt;
  logic [EFF_W-1:0] eff_r, eff_nxt;
  logic [SEQ_W-1:0] timeouts_r, timeouts_nxt;
  logic [SEQ_W-1:0] fastrx_r, fastrx_nxt;
  logic             finished_r, finished_nxt;
  logic [9:0]       mindev_r, mindev_nxt;
  logic [SEQ_W-1:0] total_r, total_nxt;

  // pending advancing ACK
  logic [SEQ_W-1:0] ack_r, ack_nxt;
  logic [EFF_W-1:0] win_r, win_nxt;
  logic             ge2_r, ge2_nxt;
  logic             take_r, take_nxt;
  logic [SEQ_W-1:0] base_tx_r, base_tx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_action_r;
  logic [SEQ_W-1:0] out_pseq_r, out_base_r, out_next_r, out_rto_r;
  logic [SEQ_W-1:0] out_tmo_r, out_fast_r;
  logic [RTT_W-1:0] out_est_r, out_dev_r;
  logic [EFF_W-1:0] out_eff_r;

  logic             accept;
  logic             cfg_acc;
  logic             prod;
  logic [2:0]       act;
  logic [SEQ_W-1:0] pseq;
  logic [SEQ_W-1:0] outstanding;
  logic [SEQ_W-1:0] ack_d;
  logic [SEQ_W-1:0] now_inc;
  logic [2:0]       dup_inc;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [SEQ_W-1:0]  wr_data;
  logic [SLOT_W-1:0] rd_addr_a, rd_addr_b;
  logic [SEQ_W-1:0]  rd_data_a, rd_data_b;

  rtt_cmd_t  rcmd;
  rtt_stat_t rstat;

  sws_ring u_ring (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  sws_rtt u_rtt (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (rcmd),
    .stat  (rstat)
  );

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid & in_ready;

  always_comb begin
    outstanding = next_r - base_r;
    ack_d       = in_ack_seq - base_r;
    now_inc     = now_r + 32'd1;
    dup_inc     = (dup_r < DUP_MAX) ? dup_r + 3'd1 : dup_r;

    state_nxt    = state_r;
    base_nxt     = base_r;
    next_nxt     = next_r;
    now_nxt      = now_r;
    timer_nxt    = timer_r;
    dup_nxt      = dup_r;
    eff_nxt      = eff_r;
    timeouts_nxt = timeouts_r;
    fastrx_nxt   = fastrx_r;
    finished_nxt = finished_r;
    mindev_nxt   = mindev_r;
    total_nxt    = total_r;
    ack_nxt      = ack_r;
    win_nxt      = win_r;
    ge2_nxt      = ge2_r;
    take_nxt     = take_r;
    base_tx_nxt  = base_tx_r;

    prod = 1'b0;
    act  = ACT_NONE;
    pseq = '0;

    wr_en     = 1'b0;
    wr_addr   = slot(next_r);
    wr_data   = now_r;
    rd_addr_a = slot(base_r);
    rd_addr_b = slot(base_r + 32'd1);

    rcmd          = '0;
    rcmd.min_dev  = mindev_r;
    rcmd.rto_init = cfg_data[15:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (finished_r) begin
            prod = 1'b1;
            act  = ACT_DONE;
          end else begin
            case (in_mode)
              MODE_SEND: begin
                prod = 1'b1;
                if (outstanding >= {21'b0, eff_r}) begin
                  act = ACT_REFUSED;
                end else begin
                  if (outstanding == '0) begin
                    timer_nxt = now_r + rstat.rto;
                  end
                  wr_en    = 1'b1;
                  pseq     = next_r;
                  next_nxt = next_r + 32'd1;
                  act      = ACT_SEND;
                end
              end
              MODE_TICK: begin
                prod    = 1'b1;
                now_nxt = now_inc;
                if ((base_r != next_r) && reached(now_inc, timer_r)) begin
                  timeouts_nxt = sat_inc(timeouts_r);
                  wr_en        = 1'b1;
                  wr_addr      = slot(base_r);
                  wr_data      = now_inc;
                  timer_nxt    = now_inc + rstat.rto;
                  pseq         = base_r;
                  act          = ACT_TIMEOUT;
                end
              end
              MODE_ACK: begin
                if (ack_d == '0) begin
                  prod = 1'b1;
                  if (outstanding != '0) begin
                    dup_nxt = dup_inc;
                    if (dup_inc == DUP_FAST) begin
                      fastrx_nxt = sat_inc(fastrx_r);
                      wr_en      = 1'b1;
                      wr_addr    = slot(base_r);
                      timer_nxt  = now_r + rstat.rto;
                      pseq       = base_r;
                      act        = ACT_FAST;
                    end
                  end
                end else if (ack_d <= outstanding) begin
                  // ring reads of base and base+1 issued by the default addresses
                  ack_nxt   = in_ack_seq;
                  win_nxt   = cap_win(in_recv_window);
                  ge2_nxt   = (outstanding >= 32'd2);
                  state_nxt = S_RD1;
                end else begin
                  prod = 1'b1;
                end
              end
              default: begin
                prod = 1'b1;
              end
            endcase
          end
        end
      end
      S_RD1: begin
        // sample only when base went out strictly before base+1
        take_nxt  = ge2_r && (rd_data_b != rd_data_a) && reached(rd_data_b, rd_data_a);
        rd_addr_a = slot(ack_r - 32'd1);
        rd_addr_b = slot(ack_r);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        rcmd.start   = 1'b1;
        rcmd.take    = take_r;
        rcmd.first   = (ack_r == 32'd1);
        rcmd.elapsed = now_r - rd_data_a;
        base_tx_nxt  = rd_data_b;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (rstat.done) begin
          base_nxt  = ack_r;
          dup_nxt   = '0;
          eff_nxt   = win_r;
          timer_nxt = (ack_r != next_r) ? base_tx_r + rstat.rto : now_r + rstat.rto;
          if (ack_r >= total_r) begin
            finished_nxt = 1'b1;
            act          = ACT_DONE;
          end
          prod      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_acc) begin
      case (cfg_index)
        CFG_INIT_WIN: begin
          eff_nxt = cap_win({21'b0, cfg_data[EFF_W-1:0]});
        end
        CFG_INIT_RTO: begin
          rcmd.rto_load = 1'b1;
          timer_nxt     = now_r + {16'b0, cfg_data[15:0]};
        end
        CFG_MIN_DEV: begin
          mindev_nxt = cfg_data[9:0];
        end
        CFG_TOTAL_PKT: begin
          total_nxt = cfg_data;
        end
        default: begin
          total_nxt = total_r;
        end
      endcase
    end

    out_valid_nxt = prod ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      now_r       <= '0;
      timer_r     <= RTO_RESET;
      dup_r       <= '0;
      eff_r       <= cap_win({21'b0, WIN_RESET});
      timeouts_r  <= '0;
      fastrx_r    <= '0;
      finished_r  <= 1'b0;
      mindev_r    <= MDEV_RESET;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      now_r       <= now_nxt;
      timer_r     <= timer_nxt;
      dup_r       <= dup_nxt;
      eff_r       <= eff_nxt;
      timeouts_r  <= timeouts_nxt;
      fastrx_r    <= fastrx_nxt;
      finished_r  <= finished_nxt;
      mindev_r    <= mindev_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ack_r     <= ack_nxt;
    win_r     <= win_nxt;
    ge2_r     <= ge2_nxt;
    take_r    <= take_nxt;
    base_tx_r <= base_tx_nxt;
    if (prod) begin
      out_action_r <= act;
      out_pseq_r   <= pseq;
      out_base_r   <= base_nxt;
      out_next_r   <= next_nxt;
      out_rto_r    <= rstat.rto;
      out_est_r    <= rstat.est;
      out_dev_r    <= rstat.dev;
      out_eff_r    <= eff_nxt;
      out_tmo_r    <= timeouts_nxt;
      out_fast_r   <= fastrx_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_action           = out_action_r;
  assign out_packet_seq       = out_pseq_r;
  assign out_window_base      = out_base_r;
  assign out_next_sequence    = out_next_r;
  assign out_rto_now          = out_rto_r;
  assign out_smoothed_rtt     = out_est_r;
  assign out_rtt_deviation    = out_dev_r;
  assign out_effective_window = out_eff_r;
  assign out_timeout_count    = out_tmo_r;
  assign out_fast_retx_count  = out_fast_r;

endmodule
